[rtl/assert_macros.svh]
// Assertion helpers for the checker file ssbm_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/ssbm_pkg.sv]
// ----------------------------------------------------------------------------
// ssbm_pkg
// Constants and controller/datapath interface types of the sparse bit matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package ssbm_pkg;

    localparam int PATCH_COUNT = 512;
    localparam int ROW_SLOTS   = 32;

    localparam int PATCH_W = 9;
    localparam int BITS_W  = 8;
    localparam int OFF_W   = PATCH_W - 3;
    localparam int ENTRY_W = OFF_W + BITS_W;
    localparam int COUNT_W = $clog2(ROW_SLOTS + 1);
    localparam int SLOT_W  = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
    localparam int ADDR_W  = $clog2(PATCH_COUNT * ROW_SLOTS);
    localparam int COL_W   = $clog2(PATCH_COUNT);

    localparam logic CMD_SET   = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic prep;
        logic cnt_latch;
        logic srch;
        logic srch_step;
        logic shift_step;
        logic shift_wr;
    } ssbm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic trivial;
        logic is_check;
        logic lo_lt_bnd;
        logic ent_match;
        logic cnt_full;
        logic k_gt_pos;
    } ssbm_stat_t;

endpackage

`default_nettype wire

[rtl/sparse_symmetric_bit_matrix_top.sv]
// ----------------------------------------------------------------------------
// sparse_symmetric_bit_matrix_top
// Symmetric pair visibility store, sorted byte entries per column.
//
//   channel   ports                                 handshake
//   command   cmd, first_patch, second_patch        start && !busy
//   result    visible, column_full                  done (one cycle)
//
// After reset a clearing pass zeroes the 512 column counts, one a cycle;
// busy stays high for that time. An equal pair goes from PREP straight to
// FINISH. A search probe passes the states SRCH and SRCH_WAIT, and a set
// shifts each entry through SHIFT_RD and SHIFT_WR, since the entry store
// has a single read port. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_symmetric_bit_matrix_top
    import ssbm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cmd,
    input  wire logic [PATCH_W-1:0] first_patch,
    input  wire logic [PATCH_W-1:0] second_patch,
    output logic                    done,
    output logic                    visible,
    output logic                    column_full
);

    ssbm_cmd_t  ctl_cmd;
    ssbm_stat_t dp_stat;

    ssbm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd_o (ctl_cmd),
        .busy  (busy),
        .done  (done)
    );

    ssbm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_i        (ctl_cmd),
        .cmd          (cmd),
        .first_patch  (first_patch),
        .second_patch (second_patch),
        .stat         (dp_stat),
        .visible      (visible),
        .column_full  (column_full)
    );

endmodule

`default_nettype wire

[rtl/ssbm_ctrl.sv]
// ----------------------------------------------------------------------------
// ssbm_ctrl
// Sequencer for clearing, binary search and sorted insert.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbm_ctrl
    import ssbm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire ssbm_stat_t stat,
    output ssbm_cmd_t       cmd_o,
    output logic            busy,
    output logic            done
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_CNT_WAIT,
        ST_SRCH,
        ST_SRCH_WAIT,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd_o.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_o.load = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd_o.prep = 1'b1;
                state_next = stat.trivial ? ST_FINISH : ST_CNT_WAIT;
            end
            ST_CNT_WAIT:
            begin
                cmd_o.cnt_latch = 1'b1;
                state_next      = ST_SRCH;
            end
            ST_SRCH:
            begin
                cmd_o.srch = 1'b1;
                if (stat.lo_lt_bnd)
                    state_next = ST_SRCH_WAIT;
                else if (stat.is_check || stat.cnt_full)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SHIFT_RD;
            end
            ST_SRCH_WAIT:
            begin
                cmd_o.srch_step = 1'b1;
                state_next      = stat.ent_match ? ST_FINISH : ST_SRCH;
            end
            ST_SHIFT_RD:
            begin
                cmd_o.shift_step = 1'b1;
                state_next       = stat.k_gt_pos ? ST_SHIFT_WR : ST_FINISH;
            end
            ST_SHIFT_WR:
            begin
                cmd_o.shift_wr = 1'b1;
                state_next     = ST_SHIFT_RD;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= (state_next == ST_FINISH);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/ssbm_dpath.sv]
// ----------------------------------------------------------------------------
// ssbm_dpath
// Column count store, entry store, search bounds and shift pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module ssbm_dpath
    import ssbm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ssbm_cmd_t          cmd_i,
    input  wire logic               cmd,
    input  wire logic [PATCH_W-1:0] first_patch,
    input  wire logic [PATCH_W-1:0] second_patch,
    output ssbm_stat_t              stat,
    output logic                    visible,
    output logic                    column_full
);

    // Memories
    logic [COUNT_W-1:0] cnt_mem [PATCH_COUNT];
    logic [ENTRY_W-1:0] ent_mem [PATCH_COUNT * ROW_SLOTS];
    logic [COUNT_W-1:0] cnt_rdata_reg;
    logic [ENTRY_W-1:0] ent_rdata_reg;

    // Control state
    logic [PATCH_W-1:0] clr_idx_reg;

    // Item registers
    logic               op_reg;
    logic [PATCH_W-1:0] col_reg;
    logic [PATCH_W-1:0] hi_reg;
    logic               eq_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] lo_reg;
    logic [COUNT_W-1:0] bnd_reg;
    logic [COUNT_W-1:0] mid_reg;
    logic [COUNT_W-1:0] k_reg;
    logic               vis_reg;
    logic               full_reg;

    logic [PATCH_W-1:0] col_in, hi_in;
    logic [COUNT_W-1:0] mid;
    logic [COUNT_W-1:0] k_dec;
    logic [OFF_W-1:0]   byte_off;
    logic [BITS_W-1:0]  bit_mask;
    logic [OFF_W-1:0]   rd_off;
    logic [BITS_W-1:0]  rd_bits;

    logic               ent_re;
    logic [SLOT_W-1:0]  ent_rslot;
    logic               ent_we;
    logic [SLOT_W-1:0]  ent_wslot;
    logic [ENTRY_W-1:0] ent_wdata;
    logic               cnt_we;
    logic [COL_W-1:0]   cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;

    assign col_in   = (first_patch < second_patch) ? first_patch : second_patch;
    assign hi_in    = (first_patch < second_patch) ? second_patch : first_patch;
    assign mid      = lo_reg + ((bnd_reg - lo_reg) >> 1);
    assign k_dec    = k_reg - COUNT_W'(1);
    assign byte_off = hi_reg[PATCH_W-1:3];
    assign bit_mask = BITS_W'(1) << hi_reg[2:0];
    assign rd_off   = ent_rdata_reg[ENTRY_W-1:BITS_W];
    assign rd_bits  = ent_rdata_reg[BITS_W-1:0];

    // Entry store port selection
    always_comb
    begin
        ent_re    = 1'b0;
        ent_rslot = mid[SLOT_W-1:0];
        ent_we    = 1'b0;
        ent_wslot = mid_reg[SLOT_W-1:0];
        ent_wdata = {byte_off, rd_bits | bit_mask};
        cnt_we    = 1'b0;
        cnt_waddr = clr_idx_reg[COL_W-1:0];
        cnt_wdata = '0;
        if (cmd_i.clr_step)
            cnt_we = 1'b1;
        if (cmd_i.srch && (lo_reg < bnd_reg))
            ent_re = 1'b1;
        if (cmd_i.srch_step && (rd_off == byte_off) && (op_reg == CMD_SET))
            ent_we = 1'b1;
        if (cmd_i.shift_step)
        begin
            if (k_reg > lo_reg)
            begin
                ent_re    = 1'b1;
                ent_rslot = k_dec[SLOT_W-1:0];
            end
            else
            begin
                // insert the new byte at the search position
                ent_we    = 1'b1;
                ent_wslot = lo_reg[SLOT_W-1:0];
                ent_wdata = {byte_off, bit_mask};
                cnt_we    = 1'b1;
                cnt_waddr = col_reg[COL_W-1:0];
                cnt_wdata = cnt_reg + COUNT_W'(1);
            end
        end
        if (cmd_i.shift_wr)
        begin
            ent_we    = 1'b1;
            ent_wslot = k_reg[SLOT_W-1:0];
            ent_wdata = ent_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[base_reg + ADDR_W'(ent_wslot)] <= ent_wdata;
        if (ent_re)
            ent_rdata_reg <= ent_mem[base_reg + ADDR_W'(ent_rslot)];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cmd_i.prep)
            cnt_rdata_reg <= cnt_mem[col_reg[COL_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_idx_reg <= '0;
        else if (cmd_i.clr_step)
            clr_idx_reg <= clr_idx_reg + PATCH_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            op_reg   <= cmd;
            col_reg  <= col_in;
            hi_reg   <= hi_in;
            eq_reg   <= (first_patch == second_patch);
            vis_reg  <= 1'b0;
            full_reg <= 1'b0;
        end
        if (cmd_i.prep)
        begin
            base_reg <= ADDR_W'(col_reg) * ADDR_W'(ROW_SLOTS);
            vis_reg  <= eq_reg && (op_reg == CMD_CHECK);
        end
        if (cmd_i.cnt_latch)
        begin
            lo_reg  <= '0;
            bnd_reg <= cnt_rdata_reg;
            cnt_reg <= cnt_rdata_reg;
        end
        if (cmd_i.srch)
        begin
            if (lo_reg < bnd_reg)
                mid_reg <= mid;
            else
            begin
                k_reg    <= cnt_reg;
                full_reg <= (op_reg == CMD_SET) && (cnt_reg >= COUNT_W'(ROW_SLOTS));
            end
        end
        if (cmd_i.srch_step)
        begin
            if (rd_off < byte_off)
                lo_reg <= mid_reg + COUNT_W'(1);
            else if (rd_off > byte_off)
                bnd_reg <= mid_reg;
            else if (op_reg == CMD_CHECK)
                vis_reg <= |(rd_bits & bit_mask);
        end
        if (cmd_i.shift_wr)
            k_reg <= k_dec;
    end

    assign stat.clr_last  = (32'(clr_idx_reg) == PATCH_COUNT - 1);
    assign stat.trivial   = eq_reg || (32'(hi_reg) >= PATCH_COUNT);
    assign stat.is_check  = (op_reg == CMD_CHECK);
    assign stat.lo_lt_bnd = (lo_reg < bnd_reg);
    assign stat.ent_match = (rd_off == byte_off);
    assign stat.cnt_full  = (cnt_reg >= COUNT_W'(ROW_SLOTS));
    assign stat.k_gt_pos  = (k_reg > lo_reg);

    assign visible     = vis_reg;
    assign column_full = full_reg;

endmodule

`default_nettype wire

[rtl/ssbm_chk.sv]
// ----------------------------------------------------------------------------
// ssbm_chk
// Port-level checks on the sparse bit matrix, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module ssbm_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       cmd,
    input wire logic [8:0] first_patch,
    input wire logic [8:0] second_patch,
    input wire logic       done,
    input wire logic       visible,
    input wire logic       column_full
);

    // result strobe lasts a single cycle
    `ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)
    // an accepted word keeps the block busy in the next cycle
    `ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // a result is only shown while the item still holds the block
    `ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    // a check never reports a full column, a set never reports visible
    `ASSERT_IMP(a_flags_excl, clk, rst_n, done, !(visible && column_full))

endmodule

bind sparse_symmetric_bit_matrix_top ssbm_chk u_ssbm_chk (.*);

`default_nettype wire
